FILE: src/dual_antenna_gnss_heading_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-antenna heading block
// Shared property wrappers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_ANTENNA_GNSS_HEADING_TOP_DEFINES_SVH
`define DUAL_ANTENNA_GNSS_HEADING_TOP_DEFINES_SVH

// Implication checked every clock, disabled during reset.
`define DAH_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dah assertion failed");

// Next-cycle implication.
`define DAH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dah assertion failed");

`endif

FILE: src/dah_pkg.sv
// ----------------------------------------------------------------------------
// dah_pkg
// Types, constants and the arctangent table of the heading block.
// ----------------------------------------------------------------------------
package dah_pkg;

  typedef struct packed {
    logic        mode;
    logic [47:0] latitude;
    logic [47:0] longitude;
    logic [2:0]  fix_status;
    logic [62:0] stamp_ns;
  } dah_in_t;

  typedef struct packed {
    logic [23:0] heading_angle;
    logic [30:0] quat_z;
    logic [31:0] quat_w;
    logic [16:0] measured_mm;
  } dah_out_t;

  localparam logic [1:0] CfgMinQual  = 2'd0;
  localparam logic [1:0] CfgMaxAge   = 2'd1;
  localparam logic [1:0] CfgBaseline = 2'd2;

  localparam logic signed [63:0] InvGain    = 64'sd652032874;
  localparam logic [63:0]        MmPerUnit  = 64'd156543034;
  localparam logic [63:0]        Quarter    = 64'h4000000000000000;
  localparam logic [63:0]        Half       = 64'h8000000000000000;
  localparam logic signed [63:0] NeLimit    = 64'sd2147483648;
  localparam logic signed [63:0] OneQ30     = 64'sd1073741824;
  localparam int                 TabLen     = 48;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ROT1, S_EAST, S_EAST2, S_VEC, S_LEN, S_LEN2,
    S_ROT2, S_OUT
  } dah_state_e;

  // atan(2^-i) in units of 2^64 per turn
  function automatic logic [63:0] atan_lut(input logic [5:0] i);
    case (i)
      6'd0:  atan_lut = 64'h2000000000000000;
      6'd1:  atan_lut = 64'h12E4051D9DF30800;
      6'd2:  atan_lut = 64'h09FB385B5EE39E80;
      6'd3:  atan_lut = 64'h051111D41DDD9A40;
      6'd4:  atan_lut = 64'h028B0D430E589B20;
      6'd5:  atan_lut = 64'h0145D7E159046278;
      6'd6:  atan_lut = 64'h00A2F61E5C282630;
      6'd7:  atan_lut = 64'h00517C5511D442B0;
      6'd8:  atan_lut = 64'h0028BE5346D0C338;
      6'd9:  atan_lut = 64'h00145F2EBB30AAA6;
      6'd10: atan_lut = 64'h000A2F980091BA7B;
      6'd11: atan_lut = 64'h000517CC14A80CB7;
      6'd12: atan_lut = 64'h00028BE60CDFEC62;
      6'd13: atan_lut = 64'h000145F306C172F2;
      6'd14: atan_lut = 64'h0000A2F9836AE913;
      6'd15: atan_lut = 64'h0000517CC1B6C8A9;
      6'd16: atan_lut = 64'h000028BE60DB85FC;
      6'd17: atan_lut = 64'h0000145F306DC7C6;
      6'd18: atan_lut = 64'h00000A2F9836E46C;
      6'd19: atan_lut = 64'h00000517CC1B7268;
      6'd20: atan_lut = 64'h0000028BE60DB939;
      6'd21: atan_lut = 64'h00000145F306DC9C;
      6'd22: atan_lut = 64'h000000A2F9836E4E;
      6'd23: atan_lut = 64'h000000517CC1B727;
      6'd24: atan_lut = 64'h00000028BE60DB93;
      6'd25: atan_lut = 64'h000000145F306DC9;
      6'd26: atan_lut = 64'h0000000A2F9836E4;
      6'd27: atan_lut = 64'h0000000517CC1B72;
      6'd28: atan_lut = 64'h000000028BE60DB9;
      6'd29: atan_lut = 64'h0000000145F306DC;
      6'd30: atan_lut = 64'h00000000A2F9836E;
      6'd31: atan_lut = 64'h00000000517CC1B7;
      6'd32: atan_lut = 64'h0000000028BE60DB;
      6'd33: atan_lut = 64'h00000000145F306D;
      6'd34: atan_lut = 64'h000000000A2F9836;
      6'd35: atan_lut = 64'h000000000517CC1B;
      6'd36: atan_lut = 64'h00000000028BE60D;
      6'd37: atan_lut = 64'h000000000145F306;
      6'd38: atan_lut = 64'h0000000000A2F983;
      6'd39: atan_lut = 64'h0000000000517CC1;
      6'd40: atan_lut = 64'h000000000028BE60;
      6'd41: atan_lut = 64'h0000000000145F30;
      6'd42: atan_lut = 64'h00000000000A2F98;
      6'd43: atan_lut = 64'h00000000000517CC;
      6'd44: atan_lut = 64'h0000000000028BE6;
      6'd45: atan_lut = 64'h00000000000145F3;
      6'd46: atan_lut = 64'h000000000000A2F9;
      6'd47: atan_lut = 64'h000000000000517C;
      default: atan_lut = 64'd0;
    endcase
  endfunction

endpackage

FILE: src/dual_antenna_gnss_heading_top.sv
// ----------------------------------------------------------------------------
// dual_antenna_gnss_heading_top
// Dual-antenna GNSS heading from left/right fixes, iterative CORDIC.
// ----------------------------------------------------------------------------
// Each input transfer is one fix from the left or right antenna; it is stored
// in that antenna's slot and, when both fixes pass the quality, age, distance
// and baseline checks, one result transfer carries the heading, the yaw
// quaternion z/w and the measured baseline. A fix that yields a result goes
// through the check state, a CORDIC rotation for the cosine of the mean
// latitude, the east multiply (S_EAST, S_EAST2), a CORDIC vectoring of
// north/east, the length multiplies (S_LEN, S_LEN2), a CORDIC quaternion
// rotation and the output state; each of the three CORDIC passes runs
// CORDIC_STEPS iterations through the single shared shift-add/angle unit. A
// fix rejected on status, age or north distance is dropped in the check
// state, one rejected on east distance at the end of the east multiply, one
// rejected on the baseline window at the end of the quaternion rotation.
// in_ready_o is high only when the sequencer is idle; a finished result sits
// in the output register until taken, and the next fix may already be
// accepted then. A second result waits in the output state while the
// register is still full.
// ----------------------------------------------------------------------------
module dual_antenna_gnss_heading_top #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dah_pkg::dah_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dah_pkg::dah_out_t   out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [39:0]         cfg_data_i
);
  import dah_pkg::*;
`include "dual_antenna_gnss_heading_top_defines.svh"

  localparam int StepW = $clog2(CORDIC_STEPS + 1);

  // configuration
  logic [2:0]  min_q_q;
  logic [39:0] max_age_q;
  logic [15:0] base_q;

  // antenna slots
  logic signed [47:0] llat_q, llon_q, rlat_q, rlon_q;
  logic signed [2:0]  lst_q, rst_q;
  logic [62:0]        ltm_q, rtm_q;

  dah_state_e state_q, state_d;

  // shared CORDIC datapath
  logic signed [63:0] x_q, y_q;
  logic [63:0]        z_q;
  logic [StepW-1:0]   step_q;
  logic               flip_q;
  logic signed [63:0] north_q, east_q, cos_q;
  logic [63:0]        prod_q, ang_q;
  logic [63:0]        m40_q;
  logic               ovalid_q;
  dah_out_t           odata_q;

  logic               in_xfer, last_step;
  logic signed [63:0] dx, dy;
  logic [63:0]        atan_v;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign last_step   = (step_q == StepW'(CORDIC_STEPS - 1));
  assign dx          = y_q >>> step_q;
  assign dy          = x_q >>> step_q;
  assign atan_v      = (32'(step_q) < TabLen) ? atan_lut(6'(step_q)) : 64'd0;

  // check-stage values, from the slots
  logic signed [63:0] lim, nlat, sumlat, dlon;
  logic [62:0]        dt;
  logic               ok_chk;
  logic [63:0]        rot_a;
  assign lim    = 64'($signed({1'b0, min_q_q})) - 64'sd2;
  assign dt     = (ltm_q > rtm_q) ? ltm_q - rtm_q : rtm_q - ltm_q;
  assign nlat   = 64'(llat_q) - 64'(rlat_q);
  assign sumlat = 64'(llat_q) + 64'(rlat_q);
  assign dlon   = 64'(llon_q) - 64'(rlon_q);
  assign ok_chk = (64'(lst_q) >= lim) && (64'(rst_q) >= lim) && (dt <= 63'(max_age_q))
                  && (nlat <= NeLimit) && (nlat >= -NeLimit);
  assign rot_a  = 64'(sumlat) << 15;

  // east magnitude: |dlon| < 2^49 split at bit 24, |cos| < 2^32
  logic [63:0]        u_abs, c_abs, emag;
  logic [56:0]        emul_hi;
  logic [55:0]        emul_lo;
  logic signed [63:0] east_v;
  assign u_abs   = dlon[63] ? 64'(-dlon) : 64'(dlon);
  assign c_abs   = cos_q[63] ? 64'(-cos_q) : 64'(cos_q);
  assign emul_hi = {32'd0, u_abs[48:24]} * {25'd0, c_abs[31:0]};
  assign emul_lo = {32'd0, u_abs[23:0]} * {24'd0, c_abs[31:0]};
  assign emag    = (prod_q >> 6) + ((((prod_q & 64'd63) << 24) + 64'(emul_lo)) >> 30);
  assign east_v  = (dlon[63] != cos_q[63]) ? -64'(emag) : 64'(emag);

  // length: vector magnitude below 2^63, so x >> 28 fits 35 bits
  logic [34:0] len_x;
  logic [64:0] len_mul;
  logic [62:0] m40_mul;
  assign len_x   = (x_q > 0) ? x_q[62:28] : '0;
  assign len_mul = {30'd0, len_x} * {35'd0, InvGain[29:0]};
  assign m40_mul = {28'd0, prod_q[34:0]} * {35'd0, MmPerUnit[27:0]};

  logic [63:0] hval;
  assign hval = ang_q + Quarter;

  // baseline window: drop result outside [0.5, 2] x expected
  logic base_ok;
  assign base_ok = (m40_q >= (64'(base_q) << 39)) && (m40_q <= (64'(base_q) << 41));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_CHECK;
      S_CHECK: state_d = ok_chk ? S_ROT1 : S_IDLE;
      S_ROT1:  if (last_step) state_d = S_EAST;
      S_EAST:  state_d = S_EAST2;
      S_EAST2: state_d = (emag > 64'(NeLimit)) ? S_IDLE : S_VEC;
      S_VEC:   if (last_step) state_d = S_LEN;
      S_LEN:   state_d = S_LEN2;
      S_LEN2:  state_d = S_ROT2;
      S_ROT2:  if (last_step) state_d = base_ok ? S_OUT : S_IDLE;
      S_OUT:   if (!ovalid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      min_q_q   <= 3'd1;
      max_age_q <= 40'd500000000;
      base_q    <= 16'd1100;
      llat_q <= '0; llon_q <= '0; lst_q <= '0; ltm_q <= '0;
      rlat_q <= '0; rlon_q <= '0; rst_q <= '0; rtm_q <= '0;
      ovalid_q  <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgMinQual:  min_q_q   <= cfg_data_i[2:0];
          CfgMaxAge:   max_age_q <= cfg_data_i;
          CfgBaseline: base_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        if (in_data_i.mode) begin
          rlat_q <= in_data_i.latitude; rlon_q <= in_data_i.longitude;
          rst_q  <= in_data_i.fix_status; rtm_q <= in_data_i.stamp_ns;
        end else begin
          llat_q <= in_data_i.latitude; llon_q <= in_data_i.longitude;
          lst_q  <= in_data_i.fix_status; ltm_q <= in_data_i.stamp_ns;
        end
      end
      if (state_q == S_ROT1 || state_q == S_VEC || state_q == S_ROT2)
        step_q <= last_step ? '0 : step_q + StepW'(1);
      else
        step_q <= '0;
      if (state_q == S_OUT && !ovalid_q) ovalid_q <= 1'b1;
    end
  end

  function automatic logic [30:0] clamp_z(input logic signed [63:0] v);
    if (v < 0) clamp_z = '0;
    else if (v > OneQ30) clamp_z = 31'(OneQ30);
    else clamp_z = 31'(v);
  endfunction

  function automatic logic [31:0] clamp_w(input logic signed [63:0] v);
    if (v < -OneQ30) clamp_w = 32'(-OneQ30);
    else if (v > OneQ30) clamp_w = 32'(OneQ30);
    else clamp_w = 32'(v);
  endfunction

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_CHECK: begin
        flip_q  <= rot_a[63] ^ rot_a[62];
        z_q     <= (rot_a[63] ^ rot_a[62]) ? rot_a + Half : rot_a;
        x_q     <= InvGain;
        y_q     <= '0;
        north_q <= nlat;
      end
      S_ROT1, S_ROT2: begin
        if (!z_q[63]) begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_v;
        end
        if (state_q == S_ROT1 && last_step)
          cos_q <= flip_q ? -(x_q - (z_q[63] ? -dx : dx))
                          : (x_q - (z_q[63] ? -dx : dx));
      end
      S_EAST: prod_q <= 64'(emul_hi);
      S_EAST2: begin
        east_q <= east_v;
        x_q    <= north_q[63] ? -(north_q <<< 28) : (north_q <<< 28);
        y_q    <= north_q[63] ? -(east_v <<< 28) : (east_v <<< 28);
        z_q    <= north_q[63] ? Half : 64'd0;
      end
      S_VEC: begin
        if (!y_q[63]) begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_v;
        end else begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_v;
        end
      end
      S_LEN: begin
        if (north_q == 0 && east_q == 0) begin
          ang_q  <= '0;
          prod_q <= '0;
        end else begin
          ang_q  <= z_q;
          prod_q <= 64'(len_mul >> 30);
        end
      end
      S_LEN2: begin
        m40_q  <= {1'b0, m40_mul};
        flip_q <= ((hval >> 1) + Quarter) >> 63 != 0;
        z_q    <= (((hval >> 1) + Quarter) >> 63 != 0) ? (hval >> 1) + Half : (hval >> 1);
        x_q    <= InvGain;
        y_q    <= '0;
      end
      S_OUT: begin
        if (!ovalid_q) begin
          odata_q.heading_angle <= 24'((hval + 64'd549755813888) >> 40);
          odata_q.quat_z <= clamp_z(flip_q ? -y_q : y_q);
          odata_q.quat_w <= clamp_w(flip_q ? -x_q : x_q);
          odata_q.measured_mm <= 17'((m40_q + 64'd549755813888) >> 40);
        end
      end
      default: ;
    endcase
  end

  `DAH_ASSERT(a_rdy_idle, in_ready_o, state_q == S_IDLE)
  `DAH_ASSERT_NEXT(a_chk_go, state_q == S_CHECK && ok_chk, state_q == S_ROT1)
  `DAH_ASSERT(a_step_rng, 1'b1, step_q < StepW'(CORDIC_STEPS))
  `DAH_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
endmodule
